@@ sv/md5_pkg.sv @@
// MD5 engine package: initial chaining values, additive constants and
// per-step helper functions (rotation, message word index, round function).
// No dependencies.
`default_nettype none

package md5_pkg;

   localparam logic [31:0] IV_TABLE [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   localparam logic [31:0] K_TABLE [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] ROT_TABLE [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // rotation amount of a step: by round and step position within a group of four
   function automatic logic [4:0] rot_amount(input logic [5:0] step);
      return ROT_TABLE[{step[5:4], step[1:0]}];
   endfunction

   // message word used by a step
   function automatic logic [3:0] msg_index(input logic [5:0] step);
      logic [3:0] j;
      j = step[3:0];
      case (step[5:4])
         2'd0:    return j;
         2'd1:    return 4'(j * 4'd5 + 4'd1);
         2'd2:    return 4'(j * 4'd3 + 4'd5);
         default: return 4'(j * 4'd7);
      endcase
   endfunction

   // nonlinear round function
   function automatic logic [31:0] round_fn(input logic [1:0] round,
                                            input logic [31:0] b,
                                            input logic [31:0] c,
                                            input logic [31:0] d);
      case (round)
         2'd0:    return (b & c) | (~b & d);
         2'd1:    return (b & d) | (c & ~d);
         2'd2:    return b ^ c ^ d;
         default: return c ^ (b | ~d);
      endcase
   endfunction

   function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
      return (v << s) | (v >> (6'd32 - {1'b0, s}));
   endfunction

endpackage

`default_nettype wire

@@ sv/md5_hash_engine_core.sv @@
// MD5 engine: one message byte per word in, four 32-bit digest words out.
// Depends on md5_pkg; the block buffer is a 16x32 memory with a registered read.
// Bytes are taken only in idle; every 64th byte starts a compression (prefetch in
// LOAD0/LOAD1, 64 steps, chaining add) in the one-step round unit, under req_stall.
// End of message: up to 18 padding word writes and one or two compressions, then
// the digest drains from an output buffer. Sync reset restores the initial chain.
`default_nettype none

module md5_hash_engine_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_byte_valid,
   input  wire logic        req_end_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic [1:0]       rsp_word_number,
   output logic             rsp_final_word
);
   import md5_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PAD80, ST_PADZ, ST_PADL0, ST_PADL1,
      ST_LOAD0, ST_LOAD1, ST_COMP, ST_FINISH, ST_DONE
   } state_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [31:0] chain_ff [4];
   logic [31:0] chain_in [4];
   logic [31:0] obuf_ff [4];
   logic [31:0] obuf_in [4];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [31:0] pre_ff, pre_in;
   logic [31:0] acc_ff, acc_in;
   logic [63:0] bits_ff, bits_in;
   logic [5:0]  pos_ff, pos_in;
   logic [3:0]  wp_ff, wp_in;
   logic [5:0]  step_ff, step_in;
   logic [2:0]  ocnt_ff, ocnt_in;
   logic [1:0]  oidx_ff, oidx_in;

   // block buffer
   logic [31:0] block_mem [16];
   logic [31:0] rd_data_ff;
   logic        wr_en;
   logic [3:0]  wr_addr, rd_addr;
   logic [31:0] wr_data;

   logic        req_take, rsp_take;
   logic [31:0] byte_word, pad_word, step_sum, step_rot;
   logic [5:0]  step_next;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   assign rsp_valid       = (ocnt_ff != 3'd0);
   assign rsp_digest_word = obuf_ff[oidx_ff];
   assign rsp_word_number = oidx_ff;
   assign rsp_final_word  = (oidx_ff == 2'd3);

   // byte lane merge and padding marker merge
   assign byte_word = (pos_ff[1:0] == 2'd0) ? {24'd0, req_data_byte}
                    : acc_ff | ({24'd0, req_data_byte} << {pos_ff[1:0], 3'b000});
   assign pad_word  = (pos_ff[1:0] == 2'd0) ? 32'h0000_0080
                    : acc_ff | (32'h0000_0080 << {pos_ff[1:0], 3'b000});

   // one compression step; pre_ff already holds a + K + M
   assign step_next = step_ff + 6'd1;
   assign step_sum  = pre_ff + round_fn(step_ff[5:4], b_ff, c_ff, d_ff);
   assign step_rot  = rotl32(step_sum, rot_amount(step_ff));

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      chain_in = chain_ff;
      obuf_in  = obuf_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      pre_in   = pre_ff;
      acc_in   = acc_ff;
      bits_in  = bits_ff;
      pos_in   = pos_ff;
      wp_in    = wp_ff;
      step_in  = step_ff;
      ocnt_in  = ocnt_ff;
      oidx_in  = oidx_ff;
      wr_en    = 1'b0;
      wr_addr  = pos_ff[5:2];
      wr_data  = byte_word;
      rd_addr  = msg_index(6'd0);

      // digest drain
      if (rsp_take) begin
         ocnt_in = ocnt_ff - 3'd1;
         oidx_in = oidx_ff + 2'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_byte_valid) begin
                  wr_en   = 1'b1;
                  acc_in  = byte_word;
                  pos_in  = pos_ff + 6'd1;
                  bits_in = bits_ff + 64'd8;
               end
               if (req_byte_valid && pos_ff == 6'h3f) begin
                  ret_in   = req_end_of_message ? ST_PAD80 : ST_IDLE;
                  state_in = ST_LOAD0;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD80;
               end
            end
         end
         // marker byte completes the current word
         ST_PAD80: begin
            wr_en   = 1'b1;
            wr_data = pad_word;
            wp_in   = pos_ff[5:2] + 4'd1;
            if (pos_ff[5:2] == 4'd15) begin
               ret_in   = ST_PADZ;
               state_in = ST_LOAD0;
            end else begin
               state_in = ST_PADZ;
            end
         end
         // zero words up to the length field
         ST_PADZ: begin
            if (wp_ff == 4'd14) begin
               state_in = ST_PADL0;
            end else begin
               wr_en   = 1'b1;
               wr_addr = wp_ff;
               wr_data = 32'd0;
               wp_in   = wp_ff + 4'd1;
               if (wp_ff == 4'd15) begin
                  ret_in   = ST_PADZ;
                  state_in = ST_LOAD0;
               end
            end
         end
         ST_PADL0: begin
            wr_en    = 1'b1;
            wr_addr  = 4'd14;
            wr_data  = bits_ff[31:0];
            state_in = ST_PADL1;
         end
         ST_PADL1: begin
            wr_en    = 1'b1;
            wr_addr  = 4'd15;
            wr_data  = bits_ff[63:32];
            ret_in   = ST_DONE;
            state_in = ST_LOAD0;
         end
         // prefetch the first message word
         ST_LOAD0: begin
            rd_addr  = msg_index(6'd0);
            state_in = ST_LOAD1;
         end
         ST_LOAD1: begin
            a_in     = chain_ff[0];
            b_in     = chain_ff[1];
            c_in     = chain_ff[2];
            d_in     = chain_ff[3];
            pre_in   = chain_ff[0] + K_TABLE[0] + rd_data_ff;
            rd_addr  = msg_index(6'd1);
            step_in  = 6'd0;
            state_in = ST_COMP;
         end
         // rounds; the next step's pre-sum uses the word read last cycle
         ST_COMP: begin
            a_in    = d_ff;
            b_in    = b_ff + step_rot;
            c_in    = b_ff;
            d_in    = c_ff;
            pre_in  = d_ff + K_TABLE[step_next] + rd_data_ff;
            rd_addr = msg_index(step_ff + 6'd2);
            step_in = step_next;
            if (step_ff == 6'h3f) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            step_in     = 6'd0;
            state_in    = ret_ff;
         end
         // hand the digest to the output buffer once it is empty
         ST_DONE: begin
            if (ocnt_ff == 3'd0) begin
               obuf_in  = chain_ff;
               ocnt_in  = 3'd4;
               oidx_in  = 2'd0;
               chain_in = IV_TABLE;
               bits_in  = 64'd0;
               pos_in   = 6'd0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         chain_ff <= IV_TABLE;
         a_ff     <= 32'd0;
         b_ff     <= 32'd0;
         c_ff     <= 32'd0;
         d_ff     <= 32'd0;
         bits_ff  <= 64'd0;
         pos_ff   <= 6'd0;
         wp_ff    <= 4'd0;
         step_ff  <= 6'd0;
         ocnt_ff  <= 3'd0;
         oidx_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         chain_ff <= chain_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
         d_ff     <= d_in;
         bits_ff  <= bits_in;
         pos_ff   <= pos_in;
         wp_ff    <= wp_in;
         step_ff  <= step_in;
         ocnt_ff  <= ocnt_in;
         oidx_ff  <= oidx_in;
      end
      pre_ff  <= pre_in;
      acc_ff  <= acc_in;
      obuf_ff <= obuf_in;
   end

   // block buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         block_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= block_mem[rd_addr];
   end

   // checks
   a_step_only_in_rounds: assert property (@(posedge clock) disable iff (reset)
      (step_ff != 6'd0) |-> (state_ff == ST_COMP))
      else $error("step counter running outside the rounds");

   a_ocnt_bound: assert property (@(posedge clock) disable iff (reset)
      ocnt_ff <= 3'd4)
      else $error("digest word count out of range");

   a_done_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && ocnt_ff == 3'd0) |=>
         (rsp_valid && chain_ff[0] == IV_TABLE[0] && bits_ff == 64'd0))
      else $error("digest handoff did not restart the chaining state");

   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_final_word) |-> (ocnt_ff == 3'd1))
      else $error("final digest word out of order");

endmodule

`default_nettype wire
